/* rtl/core/bfba_pkg.sv */
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared codes, port widths and status types of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

	localparam int REQ_W    = 2;
	localparam int SIZE_W   = 21;
	localparam int OFF_W    = 20;
	localparam int STATUS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_REALLOC = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_POOL  = 2'd2,
		ST_TABLE = 2'd3
	} status_t;

	// Progress of the free-record scan.
	typedef struct packed {
		logic done;
		logic have1;
		logic have2;
	} scan_stat_t;

endpackage

/* rtl/core/bfba_rec_mem.sv */
// ----------------------------------------------------------------------------
// bfba_rec_mem
// Block record memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bfba_rec_mem #(
	parameter int DW    = 70,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/bfba_free_scan.sv */
// ----------------------------------------------------------------------------
// bfba_free_scan
// Walks the record valid bits one per cycle and reports the first two free
// records in index order.
// ----------------------------------------------------------------------------
module bfba_free_scan #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kick,
	input  logic [MAX_BLOCKS-1:0]         valid,
	output bfba_pkg::scan_stat_t          stat,
	output logic [$clog2(MAX_BLOCKS)-1:0] idx1,
	output logic [$clog2(MAX_BLOCKS)-1:0] idx2
);
	import bfba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] LAST = CW'(MAX_BLOCKS);

	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          have1_q;
	logic          have2_q;
	logic [IW-1:0] idx1_q;
	logic [IW-1:0] idx2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			run_q   <= 1'b0;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (kick) begin
			cnt_q   <= '0;
			run_q   <= 1'b1;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (run_q) begin
			if (cnt_q == LAST) begin
				run_q <= 1'b0;
			end else begin
				if (!valid[cnt_q[IW-1:0]]) begin
					if (!have1_q) begin
						have1_q <= 1'b1;
						idx1_q  <= cnt_q[IW-1:0];
					end else begin
						have2_q <= 1'b1;
						idx2_q  <= cnt_q[IW-1:0];
						run_q   <= 1'b0;
					end
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign stat.done  = !run_q;
	assign stat.have1 = have1_q;
	assign stat.have2 = have2_q;
	assign idx1       = idx1_q;
	assign idx2       = idx2_q;

endmodule

/* rtl/core/best_fit_block_allocator_top.sv */
// An allocate or free walks the arena chains, one block record per cycle, with a
// start step for each arena; a new arena also steps through its size one page
// at a time. A reallocate that must move walks the chains three times.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset clears the valid bits, the arena count and the pool top at once.
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit allocator with block splitting and neighbour coalescing, holding
// its block records in a single-port-read synchronous memory.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top #(
	parameter int POOL_BYTES         = 1048576,
	parameter int PAGE_BYTES         = 131072,
	parameter int MAX_BLOCKS         = 256,
	parameter int MAX_ARENAS         = 8,
	parameter int BLOCK_HEADER_BYTES = 24,
	parameter int ARENA_HEADER_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [bfba_pkg::REQ_W-1:0]      req_type,
	input  logic [bfba_pkg::SIZE_W-1:0]     request_size,
	input  logic [bfba_pkg::OFF_W-1:0]      data_offset,
	output logic                            done,
	output logic [bfba_pkg::STATUS_W-1:0]   status,
	output logic [bfba_pkg::OFF_W-1:0]      result_offset,
	output logic                            copy_needed,
	output logic [bfba_pkg::OFF_W-1:0]      copy_source,
	output logic [bfba_pkg::SIZE_W-1:0]     copy_length
);
	import bfba_pkg::*;

	// Index widths for records and arenas.
	localparam int IW  = $clog2(MAX_BLOCKS);
	localparam int ACW = $clog2(MAX_ARENAS + 1);
	localparam int AIW = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
	// Header offsets fit STW bits, capacities and the pool top fit PTW bits.
	localparam int STW = $clog2(POOL_BYTES);
	localparam int PTW = $clog2(POOL_BYTES + 1);
	// Working width for sums of sizes, headers and page-rounded arena sizes.
	localparam int XW  = ((PTW > SIZE_W + 2) ? PTW : SIZE_W + 2) + 2;

	localparam logic [XW-1:0]  BH_X   = XW'(BLOCK_HEADER_BYTES);
	localparam logic [XW-1:0]  AH_X   = XW'(ARENA_HEADER_BYTES);
	localparam logic [XW-1:0]  PAGE_X = XW'(PAGE_BYTES);
	localparam logic [XW-1:0]  POOL_X = XW'(POOL_BYTES);
	localparam logic [ACW-1:0] MAXA   = ACW'(MAX_ARENAS);

	// One block record as it sits in the memory. A free block has used zero.
	typedef struct packed {
		logic [STW-1:0]    start;
		logic [PTW-1:0]    cap;
		logic [SIZE_W-1:0] used;
		logic [IW-1:0]     succ;
	} rec_t;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_WSTART = 12'b0000_0000_0010,
		S_WRUN   = 12'b0000_0000_0100,
		S_SCHK   = 12'b0000_0000_1000,
		S_PCHK   = 12'b0000_0001_0000,
		S_FIT    = 12'b0000_0010_0000,
		S_WR2    = 12'b0000_0100_0000,
		S_POST   = 12'b0000_1000_0000,
		S_ASIZE  = 12'b0001_0000_0000,
		S_NEWAR  = 12'b0010_0000_0000,
		S_WRN2   = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	// What the chain walk is doing: locating the block to act on, searching
	// for the best fit, or locating the old block again after a move.
	typedef enum logic [1:0] {
		PH_LOC1   = 2'd0,
		PH_SEARCH = 2'd1,
		PH_LOC2   = 2'd2
	} phase_t;

	state_t            state_q;
	phase_t            ph_q;
	logic [REQ_W-1:0]  op_q;
	logic [SIZE_W-1:0] size_q;
	logic [OFF_W-1:0]  doff_q;

	// Walk position.
	logic [ACW-1:0]    wa_q;
	logic [IW-1:0]     cur_q;
	logic [IW-1:0]     prev_q;
	logic              prev_ok_q;

	// The located block, or the best fit during a search.
	logic [IW-1:0]     h_idx_q;
	logic [STW-1:0]    h_start_q;
	logic [PTW-1:0]    h_cap_q;
	logic [SIZE_W-1:0] h_used_q;
	logic [IW-1:0]     h_succ_q;
	logic              h_first_q;
	logic              bf_q;
	logic [IW-1:0]     s_idx_q;
	logic              s_ok_q;
	logic [IW-1:0]     pred_q;
	logic              pred_ok_q;

	// Arena table and pool.
	logic [XW-1:0]     asz_q;
	logic [ACW-1:0]    acnt_q;
	logic [PTW-1:0]    ptop_q;
	logic [IW-1:0]     first_q [MAX_ARENAS];
	logic [MAX_BLOCKS-1:0] valid_q;

	// Result word.
	logic [STATUS_W-1:0] st_q;
	logic [XW-1:0]       off_q;
	logic                cneed_q;
	logic [XW-1:0]       csrc_q;
	logic [SIZE_W-1:0]   clen_q;

	// Registered memory write; it lands in the cycle after the decision, which
	// the sequencer always leaves before the next read of the same records.
	logic              wr_en_q;
	logic [IW-1:0]     wr_addr_q;
	rec_t              wr_data_q;

	logic [IW-1:0]     raddr;
	rec_t              rd;

	scan_stat_t        scan;
	logic [IW-1:0]     idx1;
	logic [IW-1:0]     idx2;
	logic              kick;

	logic [IW-1:0]     nxt;
	logic [IW-1:0]     cur_first;
	logic              cont;
	logic              wend;
	logic              match;
	logic [XW-1:0]     size_x;
	logic              cand;
	logic              sp;
	logic              s_free;
	logic [XW-1:0]     mcap_x;
	logic [PTW-1:0]    m_cap;
	logic [IW-1:0]     m_succ;
	logic              grow_ok;
	logic [XW-1:0]     need_x;
	logic              pool_ok;
	logic [XW-1:0]     rest_x;
	logic              two;
	logic [XW-1:0]     hdr_x;
	logic [XW-1:0]     hoff_x;

	bfba_rec_mem #(
		.DW    ($bits(rec_t)),
		.DEPTH (MAX_BLOCKS)
	) u_mem (
		.clk   (clk),
		.we    (wr_en_q),
		.waddr (wr_addr_q),
		.wdata (wr_data_q),
		.raddr (raddr),
		.rdata (rd)
	);

	// Every request restarts the free-record scan; a free or an in-place grow may
	// clear valid bits while it runs, but the writes that use its result wait until it is done.
	assign kick = start && (state_q == S_IDLE);

	bfba_free_scan #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.kick   (kick),
		.valid  (valid_q),
		.stat   (scan),
		.idx1   (idx1),
		.idx2   (idx2)
	);

	// The walk follows the successor link straight out of the read data, so
	// one record is visited in every cycle of the walk within an arena.
	assign cur_first = first_q[wa_q[AIW-1:0]];
	assign nxt       = rd.succ;
	assign cont      = (nxt != cur_first) && valid_q[nxt];
	assign wend      = (wa_q >= acnt_q);

	always_comb begin
		priority if (state_q == S_WSTART) begin
			raddr = cur_first;
		end else if (state_q == S_WRUN) begin
			raddr = nxt;
		end else begin
			raddr = pred_q;
		end
	end

	assign size_x  = XW'(size_q);
	assign match   = (XW'(rd.start) + BH_X) == XW'(doff_q);
	assign cand    = (rd.used == '0) && (XW'(rd.cap) >= size_x) &&
	                 (!bf_q || (rd.cap < h_cap_q));
	assign sp      = XW'(h_cap_q) > (size_x + BH_X);
	assign hoff_x  = XW'(h_start_q) + BH_X;

	// Successor data arrives in the cycle after the block was located.
	assign s_free  = s_ok_q && (s_idx_q != h_idx_q) && (rd.used == '0);
	assign mcap_x  = XW'(h_cap_q) + BH_X + XW'(rd.cap);
	assign m_cap   = s_free ? PTW'(mcap_x) : h_cap_q;
	assign m_succ  = s_free ? rd.succ : h_succ_q;
	assign grow_ok = s_free && (mcap_x >= size_x);

	// New arena sizing.
	assign need_x  = size_x + AH_X + BH_X;
	assign pool_ok = (acnt_q < MAXA) && ((XW'(ptop_q) + asz_q) <= POOL_X);
	assign rest_x  = asz_q - size_x - BH_X - AH_X;
	assign two     = rest_x > BH_X;
	assign hdr_x   = XW'(ptop_q) + AH_X;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_en_q <= 1'b0;
			acnt_q  <= '0;
			ptop_q  <= '0;
			valid_q <= '0;
		end else begin
			wr_en_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= req_type;
						size_q  <= request_size;
						doff_q  <= data_offset;
						st_q    <= ST_OK;
						off_q   <= '0;
						cneed_q <= 1'b0;
						csrc_q  <= '0;
						clen_q  <= '0;
						wa_q    <= '0;
						bf_q    <= 1'b0;
						unique case (req_type)
							REQ_ALLOC: begin
								if (request_size == '0) begin
									st_q    <= ST_ZERO;
									state_q <= S_DONE;
								end else begin
									ph_q    <= PH_SEARCH;
									state_q <= S_WSTART;
								end
							end
							REQ_FREE: begin
								ph_q    <= PH_LOC1;
								state_q <= S_WSTART;
							end
							REQ_REALLOC: begin
								if (request_size == '0) begin
									st_q    <= ST_ZERO;
									state_q <= S_DONE;
								end else begin
									ph_q    <= PH_LOC1;
									state_q <= S_WSTART;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_WSTART: begin
					if (wend) begin
						if (ph_q == PH_SEARCH) begin
							asz_q   <= '0;
							state_q <= bf_q ? S_FIT : S_ASIZE;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						cur_q     <= cur_first;
						prev_ok_q <= 1'b0;
						state_q   <= S_WRUN;
					end
				end

				S_WRUN: begin
					if ((ph_q != PH_SEARCH) && match) begin
						if (rd.used == '0) begin
							state_q <= S_DONE;
						end else begin
							h_idx_q   <= cur_q;
							h_start_q <= rd.start;
							h_cap_q   <= rd.cap;
							h_used_q  <= rd.used;
							h_succ_q  <= rd.succ;
							h_first_q <= (cur_q == cur_first);
							pred_q    <= prev_q;
							pred_ok_q <= prev_ok_q;
							s_idx_q   <= nxt;
							s_ok_q    <= cont;
							if ((op_q == REQ_REALLOC) && (ph_q == PH_LOC1) &&
							    (size_x <= XW'(rd.cap))) begin
								state_q <= S_FIT;
							end else begin
								state_q <= S_SCHK;
							end
						end
					end else begin
						if ((ph_q == PH_SEARCH) && cand) begin
							bf_q      <= 1'b1;
							h_idx_q   <= cur_q;
							h_start_q <= rd.start;
							h_cap_q   <= rd.cap;
							h_used_q  <= rd.used;
							h_succ_q  <= rd.succ;
						end
						if (cont) begin
							cur_q     <= nxt;
							prev_q    <= cur_q;
							prev_ok_q <= 1'b1;
						end else begin
							wa_q    <= wa_q + ACW'(1);
							state_q <= S_WSTART;
						end
					end
				end

				S_SCHK: begin
					if ((op_q == REQ_REALLOC) && (ph_q == PH_LOC1)) begin
						if (grow_ok) begin
							wr_en_q         <= 1'b1;
							wr_addr_q       <= h_idx_q;
							wr_data_q.start <= h_start_q;
							wr_data_q.cap   <= PTW'(mcap_x);
							wr_data_q.used  <= size_q;
							wr_data_q.succ  <= rd.succ;
							valid_q[s_idx_q] <= 1'b0;
							off_q           <= hoff_x;
							state_q         <= S_DONE;
						end else begin
							// Move: remember the old word, then search anew.
							csrc_q  <= hoff_x;
							clen_q  <= h_used_q;
							ph_q    <= PH_SEARCH;
							wa_q    <= '0;
							bf_q    <= 1'b0;
							state_q <= S_WSTART;
						end
					end else begin
						if (s_free) begin
							valid_q[s_idx_q] <= 1'b0;
						end
						if (!h_first_q && pred_ok_q) begin
							h_cap_q  <= m_cap;
							h_succ_q <= m_succ;
							state_q  <= S_PCHK;
						end else begin
							wr_en_q         <= 1'b1;
							wr_addr_q       <= h_idx_q;
							wr_data_q.start <= h_start_q;
							wr_data_q.cap   <= m_cap;
							wr_data_q.used  <= '0;
							wr_data_q.succ  <= m_succ;
							state_q         <= S_DONE;
						end
					end
				end

				S_PCHK: begin
					wr_en_q <= 1'b1;
					if (rd.used == '0) begin
						wr_addr_q       <= pred_q;
						wr_data_q.start <= rd.start;
						wr_data_q.cap   <= PTW'(XW'(rd.cap) + BH_X + XW'(h_cap_q));
						wr_data_q.used  <= '0;
						wr_data_q.succ  <= h_succ_q;
						valid_q[h_idx_q] <= 1'b0;
					end else begin
						wr_addr_q       <= h_idx_q;
						wr_data_q.start <= h_start_q;
						wr_data_q.cap   <= h_cap_q;
						wr_data_q.used  <= '0;
						wr_data_q.succ  <= h_succ_q;
					end
					state_q <= S_DONE;
				end

				S_FIT: begin
					if (sp) begin
						if (scan.done) begin
							if (!scan.have1) begin
								st_q    <= ST_TABLE;
								state_q <= S_DONE;
							end else begin
								wr_en_q         <= 1'b1;
								wr_addr_q       <= idx1;
								wr_data_q.start <= STW'(hoff_x + size_x);
								wr_data_q.cap   <= PTW'(XW'(h_cap_q) - size_x - BH_X);
								wr_data_q.used  <= '0;
								wr_data_q.succ  <= h_succ_q;
								valid_q[idx1]   <= 1'b1;
								off_q           <= hoff_x;
								state_q         <= S_WR2;
							end
						end
					end else begin
						wr_en_q         <= 1'b1;
						wr_addr_q       <= h_idx_q;
						wr_data_q.start <= h_start_q;
						wr_data_q.cap   <= h_cap_q;
						wr_data_q.used  <= size_q;
						wr_data_q.succ  <= h_succ_q;
						off_q           <= hoff_x;
						state_q         <= S_POST;
					end
				end

				S_WR2: begin
					wr_en_q         <= 1'b1;
					wr_addr_q       <= h_idx_q;
					wr_data_q.start <= h_start_q;
					wr_data_q.cap   <= PTW'(size_x);
					wr_data_q.used  <= size_q;
					wr_data_q.succ  <= idx1;
					state_q         <= S_POST;
				end

				S_POST: begin
					if ((op_q == REQ_REALLOC) && (ph_q == PH_SEARCH)) begin
						cneed_q <= 1'b1;
						ph_q    <= PH_LOC2;
						wa_q    <= '0;
						state_q <= S_WSTART;
					end else begin
						state_q <= S_DONE;
					end
				end

				S_ASIZE: begin
					// Round up to whole pages by stepping one page a cycle.
					if (asz_q < need_x) begin
						asz_q <= asz_q + PAGE_X;
					end else begin
						state_q <= S_NEWAR;
					end
				end

				S_NEWAR: begin
					if (!pool_ok) begin
						st_q    <= ST_POOL;
						state_q <= S_DONE;
					end else if (scan.done) begin
						if (!scan.have1 || (two && !scan.have2)) begin
							st_q    <= ST_TABLE;
							state_q <= S_DONE;
						end else begin
							wr_en_q         <= 1'b1;
							wr_addr_q       <= idx1;
							wr_data_q.start <= STW'(hdr_x);
							wr_data_q.cap   <= two ? PTW'(size_x) :
							                         PTW'(asz_q - AH_X - BH_X);
							wr_data_q.used  <= size_q;
							wr_data_q.succ  <= two ? idx2 : idx1;
							valid_q[idx1]   <= 1'b1;
							first_q[acnt_q[AIW-1:0]] <= idx1;
							acnt_q          <= acnt_q + ACW'(1);
							ptop_q          <= PTW'(XW'(ptop_q) + asz_q);
							off_q           <= hdr_x + BH_X;
							state_q         <= two ? S_WRN2 : S_POST;
						end
					end
				end

				S_WRN2: begin
					wr_en_q         <= 1'b1;
					wr_addr_q       <= idx2;
					wr_data_q.start <= STW'(off_q + size_x);
					wr_data_q.cap   <= PTW'(rest_x - BH_X);
					wr_data_q.used  <= '0;
					wr_data_q.succ  <= idx1;
					valid_q[idx2]   <= 1'b1;
					state_q         <= S_POST;
				end

				S_DONE: begin
					state_q <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The result word is held in registers, valid with the one strobe cycle and kept until the next request.
	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign status        = st_q;
	assign result_offset = off_q[OFF_W-1:0];
	assign copy_needed   = cneed_q;
	assign copy_source   = cneed_q ? csrc_q[OFF_W-1:0] : '0;
	assign copy_length   = cneed_q ? clen_q : '0;

endmodule

/* rtl/core/bfba_checker.sv */
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks on the allocator's command handshake and result words.
// ----------------------------------------------------------------------------
module bfba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [bfba_pkg::STATUS_W-1:0] status,
	input logic [bfba_pkg::OFF_W-1:0]    result_offset,
	input logic                          copy_needed
);
	import bfba_pkg::*;

	// An accepted command makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// A result word is only shown while a command is in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without a command in progress");

	// Each command ends with its single strobe and the block then frees up.
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block still busy after its result strobe");

	// A failed request grants nothing and asks for no copy.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((result_offset == '0) && !copy_needed))
		else $error("error result carries an offset or a copy request");

endmodule

bind best_fit_block_allocator_top bfba_checker u_bfba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.result_offset (result_offset),
	.copy_needed   (copy_needed)
);
